// File: design/strip_crosstalk_correction_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the strip crosstalk correction core
// Implication checks, sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STRIP_CROSSTALK_CORRECTION_CORE_ASSERT_SVH
`define STRIP_CROSSTALK_CORRECTION_CORE_ASSERT_SVH

// same-cycle implication
`define SCCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sccc check failed");

// next-cycle implication
`define SCCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sccc check failed");

`endif

// File: design/sccc_pkg.sv
// ----------------------------------------------------------------------------
// sccc_pkg
// Shared widths, register indexes and types of the crosstalk correction core.
// ----------------------------------------------------------------------------
package sccc_pkg;

    localparam int MAX_HITS_DEF   = 16;
    localparam int STRIP_BITS_DEF = 6;

    localparam int E_W        = 20;
    localparam int GAIN_W     = 24;
    localparam int OFF_W      = 20;
    localparam int THR_W      = 19;
    localparam int PROD_W     = GAIN_W + E_W;
    localparam int ACC_W      = 52;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_NEAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SKIP1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SKIP2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_NEAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_SKIP1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_SKIP2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd6;

    localparam logic [THR_W-1:0] THR_RESET = 19'd512;

    // per-cycle commands to every cell of the chain
    typedef struct packed {
        logic clear;
        logic ins_en;
        logic rot_en;
    } sccc_ctrl_t;

endpackage

// File: design/strip_crosstalk_correction_core.sv
// ----------------------------------------------------------------------------
// strip_crosstalk_correction_core
// Sorts the hits of one detector side and corrects each for crosstalk.
// ----------------------------------------------------------------------------
// Hits load one item per cycle, while the block is loading, into a chain of
// MAX_HITS cells that keeps them sorted by strip (stable for equal strips). The
// item marked group_end starts the compute pass: for each stored hit in turn the
// chain rotates the stored hits past one shared 24x20 multiplier, and no new
// input is taken until the whole group is computed. Results leave through an
// output register in ascending strip order; a stall on the output holds the
// whole pass. Hits beyond MAX_HITS are dropped and flagged on every result of
// the group. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module strip_crosstalk_correction_core #(
    parameter int MAX_HITS   = sccc_pkg::MAX_HITS_DEF,
    parameter int STRIP_BITS = sccc_pkg::STRIP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sccc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sccc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [STRIP_BITS-1:0]               strip_number,
    input  logic signed [sccc_pkg::E_W-1:0]     hit_energy,
    input  logic                                group_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [STRIP_BITS-1:0]               out_strip,
    output logic signed [sccc_pkg::E_W-1:0]     corrected_energy,
    output logic                                final_hit,
    output logic                                hits_dropped
);
    import sccc_pkg::*;

    `include "strip_crosstalk_correction_core_assert.svh"

    localparam int CNT_W = $clog2(MAX_HITS + 1);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam logic signed [ACC_W-1:0] E_MAX_ACC = ACC_W'(524287);
    localparam logic signed [ACC_W-1:0] E_MIN_ACC = -ACC_W'(524288);
    localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1) <<< 24;

    // configuration
    logic signed [GAIN_W-1:0] gain_near_reg, gain_skip1_reg, gain_skip2_reg;
    logic signed [OFF_W-1:0]  off_near_reg, off_skip1_reg, off_skip2_reg;
    logic [THR_W-1:0]         thr_reg;

    logic [1:0]       state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] s_reg;
    logic             ovf_reg;
    logic             grp_drop_reg;

    // target hit and pipeline
    logic [STRIP_BITS-1:0]    tgt_strip_reg;
    logic signed [E_W-1:0]    tgt_energy_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [OFF_W-1:0]  offq_reg;
    logic                     pv_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     out_valid_reg;
    logic [STRIP_BITS-1:0]    out_strip_reg;
    logic signed [E_W-1:0]    out_energy_reg;
    logic                     out_final_reg;
    logic                     out_drop_reg;

    sccc_ctrl_t ctrl;

    logic                     in_acc;
    logic                     adv;
    logic                     emit;
    logic                     full;

    // chain signals
    logic                  c_valid  [MAX_HITS];
    logic                  c_gt     [MAX_HITS];
    logic [STRIP_BITS-1:0] c_strip  [MAX_HITS];
    logic signed [E_W-1:0] c_energy [MAX_HITS];

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_LOAD);
    assign in_acc    = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(MAX_HITS));
    assign adv       = !out_valid_reg || out_ready;
    assign emit      = adv && (((state_reg == ST_CALC) && (s_reg == '0) && (k_reg != '0))
                               || (state_reg == ST_FLUSH));

    assign ctrl.ins_en = in_acc && !full;
    assign ctrl.rot_en = (state_reg == ST_CALC) && adv;
    assign ctrl.clear  = (state_reg == ST_FLUSH) && adv;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_HITS; gi++)
        begin : g_cell
            logic                  l_valid, l_gt;
            logic [STRIP_BITS-1:0] l_strip, r_strip;
            logic signed [E_W-1:0] l_energy, r_energy;
            logic                  wrap_here;

            if (gi == 0)
            begin : g_head
                assign l_valid  = 1'b1;
                assign l_gt     = 1'b0;
                assign l_strip  = '0;
                assign l_energy = '0;
            end
            else
            begin : g_body
                assign l_valid  = c_valid[gi-1];
                assign l_gt     = c_gt[gi-1];
                assign l_strip  = c_strip[gi-1];
                assign l_energy = c_energy[gi-1];
            end

            if (gi == MAX_HITS - 1)
            begin : g_tail
                assign r_strip  = c_strip[0];
                assign r_energy = c_energy[0];
            end
            else
            begin : g_mid
                assign r_strip  = c_strip[gi+1];
                assign r_energy = c_energy[gi+1];
            end

            assign wrap_here = (count_reg == CNT_W'(gi + 1));

            sccc_cell #(
                .STRIP_BITS (STRIP_BITS)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .is_first     (gi == 0),
                .new_strip    (strip_number),
                .new_energy   (hit_energy),
                .left_valid   (l_valid),
                .left_gt      (l_gt),
                .left_strip   (l_strip),
                .left_energy  (l_energy),
                .right_strip  (r_strip),
                .right_energy (r_energy),
                .wrap         (wrap_here),
                .wrap_strip   (c_strip[0]),
                .wrap_energy  (c_energy[0]),
                .valid_q      (c_valid[gi]),
                .gt_q         (c_gt[gi]),
                .strip_q      (c_strip[gi]),
                .energy_q     (c_energy[gi])
            );
        end
    endgenerate

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_near_reg  <= '0;
            gain_skip1_reg <= '0;
            gain_skip2_reg <= '0;
            off_near_reg   <= '0;
            off_skip1_reg  <= '0;
            off_skip2_reg  <= '0;
            thr_reg        <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_NEAR:  gain_near_reg  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_SKIP1: gain_skip1_reg <= cfg_data[GAIN_W-1:0];
                REG_GAIN_SKIP2: gain_skip2_reg <= cfg_data[GAIN_W-1:0];
                REG_OFF_NEAR:   off_near_reg   <= cfg_data[OFF_W-1:0];
                REG_OFF_SKIP1:  off_skip1_reg  <= cfg_data[OFF_W-1:0];
                REG_OFF_SKIP2:  off_skip2_reg  <= cfg_data[OFF_W-1:0];
                REG_THRESHOLD:  thr_reg        <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            k_reg        <= '0;
            s_reg        <= '0;
            ovf_reg      <= 1'b0;
            grp_drop_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        if (group_end)
                        begin
                            grp_drop_reg <= ovf_reg || full;
                            state_reg    <= ST_CALC;
                            k_reg        <= '0;
                            s_reg        <= '0;
                        end
                        else if (full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                end
                ST_CALC:
                begin
                    if (adv)
                    begin
                        if (s_reg == count_reg)
                        begin
                            s_reg <= '0;
                            if (k_reg == count_reg - CNT_W'(1))
                            begin
                                state_reg <= ST_FLUSH;
                            end
                            else
                            begin
                                k_reg <= k_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            s_reg <= s_reg + CNT_W'(1);
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (adv)
                    begin
                        state_reg <= ST_LOAD;
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // distance and coefficient select for the hit at the head of the chain
    logic [STRIP_BITS-1:0]    strip_gap;
    logic signed [GAIN_W-1:0] gsel;
    logic signed [OFF_W-1:0]  osel;
    logic                     near_hit;
    logic                     qual;

    always_comb
    begin
        strip_gap = (tgt_strip_reg > c_strip[0]) ? (tgt_strip_reg - c_strip[0])
                                                 : (c_strip[0] - tgt_strip_reg);
        gsel = gain_skip2_reg;
        osel = off_skip2_reg;
        if (strip_gap == STRIP_BITS'(1))
        begin
            gsel = gain_near_reg;
            osel = off_near_reg;
        end
        else if (strip_gap == STRIP_BITS'(2))
        begin
            gsel = gain_skip1_reg;
            osel = off_skip1_reg;
        end
        near_hit = (strip_gap != '0) && (strip_gap <= STRIP_BITS'(3));
        qual     = ($signed({tgt_energy_reg[E_W-1], tgt_energy_reg}) >
                    $signed({2'b00, thr_reg}))
                && ($signed({c_energy[0][E_W-1], c_energy[0]}) >
                    $signed({2'b00, thr_reg}));
    end

    // multiply, then accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (adv)
        begin
            pv_reg <= (state_reg == ST_CALC) && (s_reg != '0) && (s_reg != count_reg)
                      && near_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && (state_reg == ST_CALC))
        begin
            prod_reg <= gsel * c_energy[0];
            offq_reg <= qual ? osel : '0;
            if (s_reg == '0)
            begin
                tgt_strip_reg  <= c_strip[0];
                tgt_energy_reg <= c_energy[0];
                acc_reg        <= ACC_W'(c_energy[0]) <<< 25;
            end
            else if (pv_reg)
            begin
                acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< 1) + (ACC_W'(offq_reg) <<< 24);
            end
        end
    end

    // round half up, saturate
    logic signed [ACC_W-1:0] rnd;
    logic signed [E_W-1:0]   sat;

    always_comb
    begin
        rnd = (acc_reg + RND_HALF) >>> 25;
        priority if (rnd > E_MAX_ACC)
        begin
            sat = E_MAX_ACC[E_W-1:0];
        end
        else if (rnd < E_MIN_ACC)
        begin
            sat = E_MIN_ACC[E_W-1:0];
        end
        else
        begin
            sat = rnd[E_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_strip_reg  <= tgt_strip_reg;
            out_energy_reg <= sat;
            out_final_reg  <= (state_reg == ST_FLUSH);
            out_drop_reg   <= grp_drop_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_strip        = out_strip_reg;
    assign corrected_energy = out_energy_reg;
    assign final_hit        = out_final_reg;
    assign hits_dropped     = out_drop_reg;

    // a hit taken at capacity either marks the overflow or closes the group
    `SCCC_ASSERT_NEXT(a_ovf_set, in_acc && full && !group_end, ovf_reg)
    // compute never runs on an empty group
    `SCCC_ASSERT_NOW(a_calc_nonempty, state_reg == ST_CALC, count_reg != '0)
    // no item is taken while a group is being computed
    `SCCC_ASSERT_NOW(a_no_load_busy, state_reg != ST_LOAD, !in_ready)

endmodule

// File: design/sccc_cell.sv
// ----------------------------------------------------------------------------
// sccc_cell
// One slot of the hit chain: sorted insert on load, rotation during compute.
// ----------------------------------------------------------------------------
module sccc_cell #(
    parameter int STRIP_BITS = sccc_pkg::STRIP_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sccc_pkg::sccc_ctrl_t        ctrl,
    input  logic                        is_first,
    input  logic [STRIP_BITS-1:0]       new_strip,
    input  logic signed [sccc_pkg::E_W-1:0] new_energy,
    input  logic                        left_valid,
    input  logic                        left_gt,
    input  logic [STRIP_BITS-1:0]       left_strip,
    input  logic signed [sccc_pkg::E_W-1:0] left_energy,
    input  logic [STRIP_BITS-1:0]       right_strip,
    input  logic signed [sccc_pkg::E_W-1:0] right_energy,
    input  logic                        wrap,
    input  logic [STRIP_BITS-1:0]       wrap_strip,
    input  logic signed [sccc_pkg::E_W-1:0] wrap_energy,
    output logic                        valid_q,
    output logic                        gt_q,
    output logic [STRIP_BITS-1:0]       strip_q,
    output logic signed [sccc_pkg::E_W-1:0] energy_q
);
    import sccc_pkg::*;

    logic                  valid_reg;
    logic [STRIP_BITS-1:0] strip_reg;
    logic signed [E_W-1:0] energy_reg;
    logic                  open_slot;

    assign gt_q      = valid_reg && (strip_reg > new_strip);
    assign open_slot = !valid_reg || gt_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.ins_en && open_slot && (left_gt || is_first || left_valid))
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en && open_slot)
        begin
            if (left_gt)
            begin
                strip_reg  <= left_strip;
                energy_reg <= left_energy;
            end
            else if (is_first || left_valid)
            begin
                strip_reg  <= new_strip;
                energy_reg <= new_energy;
            end
        end
        else if (ctrl.rot_en)
        begin
            strip_reg  <= wrap ? wrap_strip  : right_strip;
            energy_reg <= wrap ? wrap_energy : right_energy;
        end
    end

    assign valid_q  = valid_reg;
    assign strip_q  = strip_reg;
    assign energy_q = energy_reg;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the strip crosstalk correction core: random and
// directed hit groups, register settings between groups, scoreboard check.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Keeps a private copy of the coefficients and the stored hits. On a group's
// last item it computes the corrected results and queues them in order.
class crosstalk_scoreboard;
    localparam int MAXH = 16;

    typedef struct {
        logic [5:0]  strip;
        logic [19:0] energy;
        logic        last;
        logic        dropped;
    } hit_result_t;

    longint gain[1:3];
    longint offs[1:3];
    longint thresh;
    logic [5:0] strips[MAXH];
    longint     energies[MAXH];
    int         count;
    bit         lost;
    hit_result_t pending[$];
    int mismatches;
    int checked;

    function new();
        gain[1] = 0; gain[2] = 0; gain[3] = 0;
        offs[1] = 0; offs[2] = 0; offs[3] = 0;
        thresh = 512;
        count = 0;
        lost = 0;
        mismatches = 0;
        checked = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] val);
        case (idx)
            sccc_pkg::REG_GAIN_NEAR:  gain[1] = longint'($signed(val));
            sccc_pkg::REG_GAIN_SKIP1: gain[2] = longint'($signed(val));
            sccc_pkg::REG_GAIN_SKIP2: gain[3] = longint'($signed(val));
            sccc_pkg::REG_OFF_NEAR:   offs[1] = longint'($signed(val[19:0]));
            sccc_pkg::REG_OFF_SKIP1:  offs[2] = longint'($signed(val[19:0]));
            sccc_pkg::REG_OFF_SKIP2:  offs[3] = longint'($signed(val[19:0]));
            sccc_pkg::REG_THRESHOLD:  thresh = longint'(val[18:0]);
            default: ;
        endcase
    endfunction

    function void note_hit(logic [5:0] s, logic [19:0] e, logic last);
        int order[MAXH];
        int j;
        int cur;
        int d;
        longint acc;
        longint ea;
        longint eb;
        longint r;
        hit_result_t res;
        if (count < MAXH)
        begin
            strips[count] = s;
            energies[count] = longint'($signed(e));
            count++;
        end
        else
            lost = 1;
        if (!last)
            return;
        // stable insertion sort by strip
        for (int i = 0; i < count; i++)
        begin
            cur = i;
            j = i;
            while (j > 0 && strips[order[j-1]] > strips[cur])
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        for (int k = 0; k < count; k++)
        begin
            ea = energies[order[k]];
            acc = ea <<< 25;
            for (int m = 0; m < count; m++)
            begin
                d = int'(strips[order[k]]) - int'(strips[order[m]]);
                if (d < 0)
                    d = -d;
                if (m == k || d < 1 || d > 3)
                    continue;
                eb = energies[order[m]];
                acc += gain[d] * eb * 2;
                if (ea > thresh && eb > thresh)
                    acc += offs[d] <<< 24;
            end
            r = (acc + (longint'(1) <<< 24)) >>> 25;
            if (r > 524287)
                r = 524287;
            if (r < -524288)
                r = -524288;
            res.strip = strips[order[k]];
            res.energy = r[19:0];
            res.last = (k == count - 1);
            res.dropped = lost;
            pending = {pending, res};
        end
        count = 0;
        lost = 0;
    endfunction

    function void check_result(logic [5:0] s, logic [19:0] e, logic f, logic dr);
        hit_result_t x;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result strip=%0d energy=%0d", s, $signed(e));
            return;
        end
        x = pending.pop_front();
        if (x.strip !== s || x.energy !== e || x.last !== f || x.dropped !== dr)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp s=%0d e=%0d f=%0d d=%0d got s=%0d e=%0d f=%0d d=%0d",
                    x.strip, $signed(x.energy), x.last, x.dropped,
                    s, $signed(e), f, dr);
        end
    endfunction
endclass

module tb_top;
    import sccc_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [5:0] strip_number;
    logic signed [E_W-1:0] hit_energy;
    logic group_end;
    logic out_valid;
    logic out_ready;
    logic [5:0] out_strip;
    logic signed [E_W-1:0] corrected_energy;
    logic final_hit;
    logic hits_dropped;

    crosstalk_scoreboard board;
    longint cycles;
    int sent;
    int groups;
    bit steady;   // no idling on either side while set

    strip_crosstalk_correction_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .strip_number(strip_number), .hit_energy(hit_energy),
        .group_end(group_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_strip(out_strip), .corrected_energy(corrected_energy),
        .final_hit(final_hit), .hits_dropped(hits_dropped)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        board = new();
        cycles = 0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("strip_crosstalk_correction_core regression: fail");
            $finish;
        end
    end

    // result side: sample at rising edge, stall ready randomly at falling edge
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_result(out_strip, corrected_energy, final_hit, hits_dropped);

    always @(negedge clk)
        if (!rst_n)
            out_ready <= 0;
        else
            out_ready <= steady || ($urandom_range(99) >= 23);

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // one item; valid is kept high when another item follows right away
    task automatic send_hit(input logic [5:0] s, input logic [19:0] e, input logic last);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 23)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        strip_number <= s;
        hit_energy <= e;
        group_end <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_hit(s, e, last);
        sent++;
        if (last)
            groups++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        // a group may still be computing with nothing yet queued: wait out a full pass
        repeat (300)
            @(posedge clk);
    endtask

    // energies spread over small, near-threshold and extreme values
    function automatic logic [19:0] pick_energy();
        case ($urandom_range(5))
            0: return 20'h7FFFF;
            1: return 20'h80000;
            2: return 20'($urandom_range(1100) - 50);
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic random_group(input int n, input int base);
        for (int i = 0; i < n; i++)
            send_hit(6'((base + $urandom_range(8)) % 64), pick_energy(), i == n - 1);
    endtask

    task automatic load_coefficients(input int mode);
        for (int r = 0; r < 7; r++)
        begin
            logic [23:0] v;
            case (mode)
                0: v = (r < 3) ? 24'h7FFFFF : (r < 6) ? 24'h07FFFF : 24'h0;
                1: v = (r < 3) ? 24'h800000 : (r < 6) ? 24'h080000 : 24'h07FFFF;
                default: v = $urandom;
            endcase
            if (mode > 1 && r == 6)
                v = $urandom_range(1) ? 24'($urandom_range(2000)) : v;
            write_reg(3'(r), v);
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        strip_number = '0;
        hit_energy = '0;
        group_end = 0;
        sent = 0;
        groups = 0;
        steady = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: single hit, reset coefficients, extremes
        send_hit(6'd0, 20'h7FFFF, 1);
        drain();
        load_coefficients(0);
        send_hit(6'd63, 20'h80000, 0);
        send_hit(6'd62, 20'h7FFFF, 0);
        send_hit(6'd60, 20'h7FFFF, 0);
        send_hit(6'd62, 20'd1000, 0);   // same strip as an earlier hit
        send_hit(6'd59, 20'd513, 1);
        drain();
        load_coefficients(1);
        // overflow: 18 hits, two dropped
        for (int i = 0; i < 18; i++)
            send_hit(6'(i * 3 % 20), (i % 2) ? 20'h7FFFF : 20'd600, i == 17);
        send_hit(6'd5, 20'd512, 0);     // below the threshold
        send_hit(6'd6, 20'd513, 1);
        drain();
        write_reg(3'd7, 24'hFFFFFF);     // unused index, ignored

        // random phases with different settings
        for (int phase = 0; phase < 6; phase++)
        begin
            drain();
            load_coefficients(phase == 5 ? 0 : 2);
            steady = (phase == 2);
            while (sent < 45 + 45 * (phase + 1))
                random_group(($urandom_range(9) == 0) ? $urandom_range(17, 20)
                                                      : $urandom_range(1, 6),
                             $urandom_range(63));
        end
        steady = 0;

        drain();
        $display("covered %0d hits in %0d groups, %0d results checked",
            sent, groups, board.checked);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("strip_crosstalk_correction_core regression: pass");
        else
            $display("strip_crosstalk_correction_core regression: fail");
        $finish;
    end
endmodule
